[rtl/scfl_pkg.sv]
// shared constants, codes and types for the size-class free-list allocator
`timescale 1ns / 1ps
package scfl_pkg;

  // heap geometry
  localparam int ALIGN_BYTES  = 8;
  localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
  localparam int SIZE_CLASSES = 16;
  localparam int CHUNK_BLOCKS = 20;
  localparam int HEAP_UNITS   = 4096;

  // field and storage widths
  localparam int SIZE_W   = 12;
  localparam int ADDR_W   = 12;
  localparam int LINK_W   = 13;
  localparam int CLS_W    = 4;
  localparam int U_W      = 5;
  localparam int UFULL_W  = 10;
  localparam int STATUS_W = 2;

  // refill split: granted block, listed blocks, pool blocks
  localparam int LIST_COUNT   = (CHUNK_BLOCKS + 1) / 2 - 1;
  localparam int POOL_BLOCKS  = CHUNK_BLOCKS >> 1;
  localparam int POOL_OFFSET  = CHUNK_BLOCKS - POOL_BLOCKS;
  localparam int POOL_W       = $clog2(SIZE_CLASSES * POOL_BLOCKS + 1);
  localparam int CHUNK_W      = $clog2(SIZE_CLASSES * CHUNK_BLOCKS + 1);
  localparam int CNT_W        = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(HEAP_UNITS);

  // stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO      = 2'd1,
    STATUS_OVERSIZE  = 2'd2,
    STATUS_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_POP,
    ST_PUSH,
    ST_REFILL,
    ST_LINK,
    ST_DONE
  } state_t;

endpackage

[rtl/scfl_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module scfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/size_class_free_list_allocator.sv]
// top level of the size-class free-list allocator
`timescale 1ns / 1ps
// usage
//   one request enters on the in_ stream: in_tuser is the action (0 allocate,
//   1 release), in_tdata carries req_size and block_address. each request
//   gives exactly one result on the out_ stream: out_tdata is granted_address,
//   out_tuser is the status (ok, zero size, oversize, heap exhausted).
//   one request is worked on at a time; in_tready is high while the engine
//   is idle. the result sits in an output register, so a stalled receiver
//   does not stop the next request from being accepted, only its completion.
//   states from accept to result valid, paced by the head and link ram reads:
//     zero size, oversize, release, pool carve: head, done
//     pop from a class list: head, pop, done; heap exhausted: head, refill, done
//     refill: head, refill, then link for each listed block ((CHUNK_BLOCKS+1)/2-1 = 9), done;
//     a pool remainder is pushed first, in a push state ahead of refill and exhausted
//   the engine is idle again as the result turns valid, so the next request
//   can be taken while that result waits on the receiver; refills are rare
//   reset (rst_n low, synchronous) empties all class lists through per-class
//   valid bits, clears pool and heap top; links are written before being read
module size_class_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [scfl_pkg::IN_DATA_W-1:0]  in_tdata,  // [11:0] req_size, [23:12] block_address
  input  logic                           in_tuser,  // [0] action
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [scfl_pkg::OUT_DATA_W-1:0] out_tdata, // [11:0] granted_address, [15:12] zero
  output logic [scfl_pkg::STATUS_W-1:0]   out_tuser  // [1:0] status
);

  import scfl_pkg::*;

  // fsm and request registers
  state_t              state_r, state_nxt;
  action_t             action_r, action_nxt;
  status_t             pre_status_r, pre_status_nxt;
  logic [U_W-1:0]      u_r, u_nxt;
  logic [CLS_W-1:0]    cls_r, cls_nxt;
  logic [ADDR_W-1:0]   baddr_r, baddr_nxt;

  // result staging and output register
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  status_t             out_status_r, out_status_nxt;

  // allocator scalar state
  logic [ADDR_W-1:0]   pool_start_r, pool_start_nxt;
  logic [POOL_W-1:0]   pool_units_r, pool_units_nxt;
  logic [LINK_W-1:0]   heap_top_r, heap_top_nxt;

  // refill link walk
  logic [ADDR_W-1:0]   blk_r, blk_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // class head ram and its per-class valid bits
  logic [SIZE_CLASSES-1:0] head_valid_r;
  logic                head_vld_r;
  logic                head_we;
  logic [CLS_W-1:0]    head_waddr, head_raddr;
  logic [LINK_W-1:0]   head_wdata, head_rdata;

  // link ram
  logic                link_we;
  logic [ADDR_W-1:0]   link_waddr, link_raddr;
  logic [LINK_W-1:0]   link_wdata, link_rdata;

  // request decode
  logic [SIZE_W-1:0]   in_size;
  logic [UFULL_W-1:0]  in_u_full;
  logic [CLS_W-1:0]    in_cls;
  status_t             in_status;

  // datapath helpers
  logic [LINK_W-1:0]   head_cur;
  logic                head_hit;
  logic                pool_fits;
  logic [POOL_W-1:0]   pool_left;
  logic [CLS_W-1:0]    pool_cls;
  logic [CHUNK_W-1:0]  chunk_units;
  logic [POOL_W-1:0]   refill_pool;
  logic [LINK_W:0]     refill_end;
  logic                exhausted;
  logic [LINK_W-1:0]   first_listed;
  logic [LINK_W-1:0]   refill_pool_start;
  logic                link_last;

  scfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SIZE_CLASSES)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (head_waddr),
    .wr_data (head_wdata),
    .rd_addr (head_raddr),
    .rd_data (head_rdata)
  );

  scfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (HEAP_UNITS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (link_raddr),
    .rd_data (link_rdata)
  );

  // round the byte size up to units; class is units minus one
  assign in_size   = in_tdata[SIZE_W-1:0];
  assign in_u_full = UFULL_W'(({1'b0, in_size} + (SIZE_W+1)'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT);
  assign in_cls    = CLS_W'(in_u_full - UFULL_W'(1));

  always_comb begin
    priority if (in_size == '0) begin
      in_status = STATUS_ZERO;
    end else if (in_u_full > UFULL_W'(SIZE_CLASSES)) begin
      in_status = STATUS_OVERSIZE;
    end else begin
      in_status = STATUS_OK;
    end
  end

  // a class that was never written since reset reads as an empty list
  assign head_cur  = head_vld_r ? head_rdata : NULL_LINK;
  assign head_hit  = head_cur < NULL_LINK;

  assign pool_fits = pool_units_r >= POOL_W'(u_r);
  assign pool_left = pool_units_r - POOL_W'(u_r);
  // remainder is smaller than the request, so its class fits the index
  assign pool_cls  = CLS_W'(pool_units_r - POOL_W'(1));

  // refill geometry from the heap top
  assign chunk_units       = CHUNK_W'(32'(u_r) * CHUNK_BLOCKS);
  assign refill_pool       = POOL_W'(32'(u_r) * POOL_BLOCKS);
  assign refill_end        = {1'b0, heap_top_r} + (LINK_W+1)'(chunk_units);
  assign exhausted         = refill_end > (LINK_W+1)'(HEAP_UNITS);
  assign first_listed      = heap_top_r + LINK_W'(u_r);
  assign refill_pool_start = heap_top_r + LINK_W'(32'(u_r) * POOL_OFFSET);

  assign link_last = cnt_r == CNT_W'(LIST_COUNT - 1);

  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    pre_status_nxt = pre_status_r;
    u_nxt          = u_r;
    cls_nxt        = cls_r;
    baddr_nxt      = baddr_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    pool_start_nxt = pool_start_r;
    pool_units_nxt = pool_units_r;
    heap_top_nxt   = heap_top_r;
    blk_nxt        = blk_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;

    head_raddr = in_cls;
    head_we    = 1'b0;
    head_waddr = cls_r;
    head_wdata = NULL_LINK;
    link_raddr = head_cur[ADDR_W-1:0];
    link_we    = 1'b0;
    link_waddr = blk_r;
    link_wdata = NULL_LINK;

    unique case (state_r)
      ST_IDLE: begin
        // head ram is read at the decoded class while waiting
        if (in_tvalid) begin
          action_nxt     = action_t'(in_tuser);
          pre_status_nxt = in_status;
          u_nxt          = in_u_full[U_W-1:0];
          cls_nxt        = in_cls;
          baddr_nxt      = in_tdata[SIZE_W +: ADDR_W];
          state_nxt      = ST_HEAD;
        end
      end

      ST_HEAD: begin
        res_addr_nxt   = '0;
        res_status_nxt = STATUS_OK;
        priority if (pre_status_r != STATUS_OK) begin
          res_status_nxt = pre_status_r;
          state_nxt      = ST_DONE;
        end else if (action_r == ACT_RELEASE) begin
          // push released block onto its class
          link_we    = 1'b1;
          link_waddr = baddr_r;
          link_wdata = head_cur;
          head_we    = 1'b1;
          head_wdata = {1'b0, baddr_r};
          state_nxt  = ST_DONE;
        end else if (head_hit) begin
          // pop: link of the head is read now, becomes the new head
          res_addr_nxt = head_cur[ADDR_W-1:0];
          state_nxt    = ST_POP;
        end else if (pool_fits) begin
          // carve from the bump pool
          res_addr_nxt   = pool_start_r;
          pool_units_nxt = pool_left;
          pool_start_nxt = (pool_left == '0) ? '0 : pool_start_r + ADDR_W'(u_r);
          state_nxt      = ST_DONE;
        end else if (pool_units_r != '0) begin
          // remainder too small: fetch its class head before pushing it
          head_raddr = pool_cls;
          state_nxt  = ST_PUSH;
        end else begin
          state_nxt = ST_REFILL;
        end
      end

      ST_POP: begin
        head_we    = 1'b1;
        head_wdata = link_rdata;
        state_nxt  = ST_DONE;
      end

      ST_PUSH: begin
        link_we        = 1'b1;
        link_waddr     = pool_start_r;
        link_wdata     = head_cur;
        head_we        = 1'b1;
        head_waddr     = pool_cls;
        head_wdata     = {1'b0, pool_start_r};
        pool_units_nxt = '0;
        pool_start_nxt = '0;
        state_nxt      = ST_REFILL;
      end

      ST_REFILL: begin
        if (exhausted) begin
          res_addr_nxt   = '0;
          res_status_nxt = STATUS_EXHAUSTED;
          state_nxt      = ST_DONE;
        end else begin
          // grant first block, list the next ones, keep the tail as pool
          res_addr_nxt   = heap_top_r[ADDR_W-1:0];
          res_status_nxt = STATUS_OK;
          heap_top_nxt   = refill_end[LINK_W-1:0];
          pool_units_nxt = refill_pool;
          pool_start_nxt = refill_pool_start[ADDR_W-1:0];
          blk_nxt        = first_listed[ADDR_W-1:0];
          cnt_nxt        = '0;
          head_we        = 1'b1;
          if (LIST_COUNT > 0) begin
            head_wdata = first_listed;
            state_nxt  = ST_LINK;
          end else begin
            head_wdata = NULL_LINK;
            state_nxt  = ST_DONE;
          end
        end
      end

      ST_LINK: begin
        // one link a cycle, in address order, last one ends the list
        link_we    = 1'b1;
        link_waddr = blk_r;
        link_wdata = link_last ? NULL_LINK : ({1'b0, blk_r} + LINK_W'(u_r));
        blk_nxt    = blk_r + ADDR_W'(u_r);
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (link_last) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // hand result to the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      pool_start_r <= '0;
      pool_units_r <= '0;
      heap_top_r   <= '0;
      head_valid_r <= '0;
      head_vld_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pool_start_r <= pool_start_nxt;
      pool_units_r <= pool_units_nxt;
      heap_top_r   <= heap_top_nxt;
      head_vld_r   <= head_valid_r[head_raddr];
      if (head_we) begin
        head_valid_r[head_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    pre_status_r <= pre_status_nxt;
    u_r          <= u_nxt;
    cls_r        <= cls_nxt;
    baddr_r      <= baddr_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    blk_r        <= blk_nxt;
    cnt_r        <= cnt_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_addr_r);
  assign out_tuser  = out_status_r;

endmodule

[rtl/scfl_checker.sv]
// port-level checks for the size-class free-list allocator, bound to the top level
`timescale 1ns / 1ps
module scfl_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [scfl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [scfl_pkg::STATUS_W-1:0]   out_tuser
);

  import scfl_pkg::*;

  // reset leaves no result pending and the engine ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("allocator not idle after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // failed requests grant nothing
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STATUS_OK) |-> out_tdata == '0)
    else $error("nonzero address with error status");

  // one request at a time
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // no result appears in the cycle right after a request is taken
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early");

endmodule

bind size_class_free_list_allocator scfl_checker u_scfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[tb/size_class_free_list_allocator_tb.sv]
// self-checking testbench for the size-class free-list allocator
`timescale 1ns / 1ps
module size_class_free_list_allocator_tb;
  import scfl_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_BYTES    = SIZE_CLASSES * ALIGN_BYTES;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } grant_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    int                units;
  } held_block_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [11:0] req_size, [23:12] block_address
  logic                  in_tuser;   // [0] action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [11:0] granted_address, [15:12] zero
  logic [STATUS_W-1:0]   out_tuser;  // [1:0] status

  // shadow of the allocator state, updated at request acceptance
  logic [LINK_W-1:0] free_heads [SIZE_CLASSES];
  logic [LINK_W-1:0] free_links [HEAP_UNITS];
  logic [ADDR_W-1:0] pool_base;
  logic [7:0]        pool_left;
  logic [LINK_W-1:0] heap_mark;

  grant_t      expected_grants[$];
  held_block_t held_blocks[$];

  int  mismatches;
  int  results_seen;
  int  requests_sent;
  int  releases_sent;
  int  status_seen [4];
  int  cycles;
  bit  quiet_tail;

  size_class_free_list_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // allocator prediction
  // ---------------------------------------------------------------------------

  task automatic clear_shadow();
    foreach (free_heads[i]) free_heads[i] = NULL_LINK;
    pool_base = '0;
    pool_left = '0;
    heap_mark = '0;
  endtask

  // push a block onto the head of its class list
  function automatic void push_free(input int cls, input logic [ADDR_W-1:0] addr);
    free_links[addr] = free_heads[cls];
    free_heads[cls]  = LINK_W'(addr);
  endfunction

  // list pop, then pool carve, then remainder push and refill from heap top
  function automatic status_t take_block(input int units, output logic [ADDR_W-1:0] addr);
    int cls;
    int chunk;
    int base;
    int blk;
    cls  = units - 1;
    addr = '0;
    if (free_heads[cls] != NULL_LINK) begin
      addr = free_heads[cls][ADDR_W-1:0];
      free_heads[cls] = free_links[addr];
      return STATUS_OK;
    end
    if (int'(pool_left) >= units) begin
      addr      = pool_base;
      pool_left = pool_left - 8'(units);
      pool_base = (pool_left == 0) ? '0 : pool_base + ADDR_W'(units);
      return STATUS_OK;
    end
    // remainder too short: park it on the class of its own size
    if (pool_left != 0) begin
      push_free(int'(pool_left) - 1, pool_base);
      pool_left = '0;
      pool_base = '0;
    end
    chunk = units * CHUNK_BLOCKS;
    if (int'(heap_mark) + chunk > HEAP_UNITS) return STATUS_EXHAUSTED;
    base      = int'(heap_mark);
    heap_mark = LINK_W'(base + chunk);
    addr      = ADDR_W'(base);
    free_heads[cls] = NULL_LINK;
    if (LIST_COUNT > 0) begin
      free_heads[cls] = LINK_W'(base + units);
      for (int i = 0; i < LIST_COUNT; i++) begin
        blk = base + units * (i + 1);
        free_links[blk] = (i + 1 < LIST_COUNT) ? LINK_W'(blk + units) : NULL_LINK;
      end
    end
    pool_left = 8'(units * POOL_BLOCKS);
    pool_base = ADDR_W'(base + chunk - units * POOL_BLOCKS);
    return STATUS_OK;
  endfunction

  function automatic grant_t predict_grant(input action_t act, input logic [SIZE_W-1:0] size,
                                           input logic [ADDR_W-1:0] baddr);
    grant_t            g;
    int                units;
    logic [ADDR_W-1:0] addr;
    g.addr   = '0;
    g.status = STATUS_OK;
    if (size == 0) begin
      g.status = STATUS_ZERO;
    end else begin
      units = (int'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES;
      if (units > SIZE_CLASSES) begin
        g.status = STATUS_OVERSIZE;
      end else if (act == ACT_RELEASE) begin
        push_free(units - 1, baddr);
      end else begin
        g.status = take_block(units, addr);
        if (g.status == STATUS_OK) g.addr = addr;
      end
    end
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // send one request, record its expected grant once it is accepted
  task automatic send_request(input action_t act, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] baddr);
    grant_t      g;
    held_block_t hb;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {baddr, size};
    do @(posedge clk); while (!in_tready);
    g = predict_grant(act, size, baddr);
    expected_grants = {expected_grants, g};
    requests_sent++;
    status_seen[g.status]++;
    if (act == ACT_RELEASE) releases_sent++;
    if (act == ACT_ALLOC && g.status == STATUS_OK) begin
      hb.addr  = g.addr;
      hb.units = (int'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES;
      held_blocks = {held_blocks, hb};
    end
  endtask

  // any byte size that rounds to the given unit count
  function automatic logic [SIZE_W-1:0] bytes_for(input int units);
    return SIZE_W'((units - 1) * ALIGN_BYTES + $urandom_range(1, ALIGN_BYTES));
  endfunction

  // hand back a random held block, with a random byte size of the same class
  task automatic release_held();
    int          idx;
    held_block_t hb;
    idx = $urandom_range(0, held_blocks.size() - 1);
    hb  = held_blocks[idx];
    held_blocks.delete(idx);
    send_request(ACT_RELEASE, bytes_for(hb.units), hb.addr);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero size and oversize on both actions, and the largest legal size
  task automatic test_reject_cases();
    send_request(ACT_ALLOC,   12'd0,    12'hfff);
    send_request(ACT_RELEASE, 12'd0,    12'hfff);
    send_request(ACT_ALLOC,   12'hfff,  12'h000);
    send_request(ACT_RELEASE, 12'hfff,  12'hfff);
    send_request(ACT_ALLOC,   SIZE_W'(MAX_BYTES + 1), 12'h000);
    send_request(ACT_RELEASE, SIZE_W'(MAX_BYTES + 1), 12'h0aa);
    send_request(ACT_ALLOC,   SIZE_W'(MAX_BYTES), 12'h555);
  endtask

  // list pop from the first refill's class list, and carving several classes from the shared pool
  task automatic test_refill_pop_carve();
    send_request(ACT_ALLOC, SIZE_W'(MAX_BYTES - 3), 12'h000);
    send_request(ACT_ALLOC, 12'd1,  12'hfff);
    send_request(ACT_ALLOC, 12'd8,  12'h000);
    send_request(ACT_ALLOC, 12'd9,  12'h000);
    send_request(ACT_ALLOC, 12'd17, 12'h000);
    send_request(ACT_ALLOC, 12'd120, 12'h000);
  endtask

  // released blocks come back first; double release and wrong size are trusted
  task automatic test_release_reuse();
    held_block_t hb;
    hb = held_blocks[held_blocks.size() - 2];
    send_request(ACT_RELEASE, bytes_for(hb.units), hb.addr);
    send_request(ACT_ALLOC,   bytes_for(hb.units), 12'h000);
    // same block handed back twice, then granted twice
    hb = held_blocks[1];
    send_request(ACT_RELEASE, bytes_for(hb.units), hb.addr);
    send_request(ACT_RELEASE, bytes_for(hb.units), hb.addr);
    send_request(ACT_ALLOC,   bytes_for(hb.units), 12'h000);
    send_request(ACT_ALLOC,   bytes_for(hb.units), 12'h000);
    // block pushed onto a class it never came from, at the top unit address
    send_request(ACT_RELEASE, 12'd24, 12'hfff);
    send_request(ACT_ALLOC,   12'd20, 12'h000);
  endtask

  // mostly allocate / release of real blocks, with some noise requests
  task automatic run_mixed_traffic(input int count, input int release_pct);
    int pick;
    logic [SIZE_W-1:0] size;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (held_blocks.size() > 0 && (pick < release_pct || held_blocks.size() > 200)) begin
        release_held();
      end else if (pick < 88) begin
        // small sizes favored so low classes see refills and pool tails
        size = ($urandom_range(0, 2) == 0) ? SIZE_W'($urandom_range(1, 24))
                                           : SIZE_W'($urandom_range(1, MAX_BYTES));
        send_request(ACT_ALLOC, size, ADDR_W'($urandom_range(0, HEAP_UNITS - 1)));
      end else if (pick < 92) begin
        send_request(action_t'($urandom_range(0, 1)), 12'd0,
                     ADDR_W'($urandom_range(0, HEAP_UNITS - 1)));
      end else if (pick < 96) begin
        send_request(action_t'($urandom_range(0, 1)),
                     SIZE_W'($urandom_range(MAX_BYTES + 1, 4095)),
                     ADDR_W'($urandom_range(0, HEAP_UNITS - 1)));
      end else begin
        // stray release of an arbitrary address
        send_request(ACT_RELEASE, SIZE_W'($urandom_range(1, MAX_BYTES)),
                     ADDR_W'($urandom_range(0, HEAP_UNITS - 1)));
      end
    end
  endtask

  // drive the heap top into the ceiling, largest class first, then the smallest
  task automatic test_heap_exhaustion();
    grant_t g;
    for (int n = 0; n < 60; n++) begin
      send_request(ACT_ALLOC, SIZE_W'(MAX_BYTES), 12'h000);
      g = expected_grants[$];
      if (g.status == STATUS_EXHAUSTED) break;
    end
    for (int n = 0; n < 60; n++) begin
      send_request(ACT_ALLOC, 12'd8, 12'h000);
      g = expected_grants[$];
      if (g.status == STATUS_EXHAUSTED) break;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               what, results_seen, exp_v, got_v);
  endtask

  always @(posedge clk) begin : check_results
    grant_t g;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_grants.size() == 0) begin
        flag_mismatch("unexpected result", -1, int'(out_tdata));
      end else begin
        g = expected_grants.pop_front();
        if (out_tdata !== OUT_DATA_W'(g.addr))
          flag_mismatch("granted_address", int'(g.addr), int'(out_tdata));
        if (out_tuser !== g.status)
          flag_mismatch("status", int'(g.status), int'(out_tuser));
      end
    end
  end

  // receiver back-pressure in random bursts, none in the tail
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycles, expected_grants.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= ACT_ALLOC;
    in_tdata   <= '0;
    quiet_tail  = 1'b0;
    clear_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reject_cases();
    test_refill_pop_carve();
    test_release_reuse();
    run_mixed_traffic(700, 30);
    test_heap_exhaustion();
    run_mixed_traffic(550, 45);
    quiet_tail = 1'b1;
    run_mixed_traffic(120, 40);
    in_tvalid <= 1'b0;

    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d releases), %0d results checked, %0d mismatches",
             requests_sent, releases_sent, results_seen, mismatches);
    $display("grants ok %0d, zero size %0d, oversize %0d, heap exhausted %0d",
             status_seen[STATUS_OK], status_seen[STATUS_ZERO],
             status_seen[STATUS_OVERSIZE], status_seen[STATUS_EXHAUSTED]);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
